FILE: rtl/brs_pkg.sv
// shared types, constants and the cordic angle table for the bezier ribbon sampler
package brs_pkg;

	localparam int COORD_W = 16;
	localparam int VAL_W   = 17;
	localparam int T_W     = 17;
	localparam int CRD_W   = 20;

	localparam logic [T_W-1:0] T_ONE    = 17'h10000;
	localparam logic [T_W-1:0] T_OFFSET = 17'd655;

	localparam logic [2:0] PASS_LX  = 3'd0;
	localparam logic [2:0] PASS_LY  = 3'd1;
	localparam logic [2:0] PASS_CX  = 3'd2;
	localparam logic [2:0] PASS_CY  = 3'd3;
	localparam logic [2:0] PASS_RX  = 3'd4;
	localparam logic [2:0] PASS_RY  = 3'd5;
	localparam logic [2:0] PASS_WID = 3'd6;

	localparam logic OP_LERP = 1'b1;
	localparam logic OP_DROP = 1'b0;
	localparam logic [3:0] PROG_LAST = 4'd8;
	// lerp, lerp, lerp, drop, lerp, lerp, drop, drop, lerp
	localparam logic [8:0] CAST_PROG = 9'b100110111;

	typedef struct packed {
		logic signed [15:0] p0_x;
		logic signed [15:0] p0_y;
		logic signed [15:0] p1_x;
		logic signed [15:0] p1_y;
		logic signed [15:0] p2_x;
		logic signed [15:0] p2_y;
		logic signed [15:0] p3_x;
		logic signed [15:0] p3_y;
		logic [15:0]        width_head;
		logic [15:0]        width_tail;
		logic [6:0]         seg_total;
	} req_t;

	typedef struct packed {
		logic [5:0]         seg_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        seg_width;
		logic signed [15:0] heading;
		logic               last;
	} res_t;

	typedef struct packed {
		logic       start_load;
		logic       div_init;
		logic       div_step;
		logic       t_fix;
		logic       load;
		logic       mul;
		logic       push;
		logic       drop;
		logic       save;
		logic       cinit;
		logic       cstep;
		logic [2:0] pass;
	} cmd_t;

	function automatic logic [15:0] atan_tab(input logic [4:0] k);
		logic [15:0] v;
		case (k)
			5'd0:    v = 16'd8192;
			5'd1:    v = 16'd4836;
			5'd2:    v = 16'd2555;
			5'd3:    v = 16'd1297;
			5'd4:    v = 16'd651;
			5'd5:    v = 16'd326;
			5'd6:    v = 16'd163;
			5'd7:    v = 16'd81;
			5'd8:    v = 16'd41;
			5'd9:    v = 16'd20;
			5'd10:   v = 16'd10;
			5'd11:   v = 16'd5;
			5'd12:   v = 16'd3;
			5'd13:   v = 16'd1;
			5'd14:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/bezier_ribbon_sampler_top.sv
// top level of the bezier ribbon sampler: controller plus datapath
//
// a request beat is taken when start is high and busy is low; req carries the
// four control points, start and end widths and the segment count (clamped to
// MAX_SEGMENTS, a count of zero yields no beats and leaves busy low).
// the block then emits one result beat per segment: strobe is high for exactly
// one cycle with result valid, last marks the final segment. results cannot be
// held off by the receiver, so no stall path exists.
// the time each segment takes is set by the bit-serial t divider, the single shared
// lerp multiplier walking 37 lerps over a shift chain and the iterative
// cordic; busy stays high until the result beat of the final segment.
// asynchronous reset returns the controller to idle; any request in flight
// is dropped.
module bezier_ribbon_sampler_top #(
	parameter int MAX_SEGMENTS = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  brs_pkg::req_t req,
	output logic          strobe,
	output brs_pkg::res_t result
);
	import brs_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int SW = $clog2(CORDIC_STEPS);

	cmd_t                cmd;
	logic [IW-1:0]       seg_idx, den;
	logic [SW-1:0]       step;
	logic                last;
	logic signed [15:0]  pos_x, pos_y, heading;
	logic [15:0]         seg_width;

	brs_ctrl #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.seg_total(req.seg_total),
		.cmd(cmd),
		.seg_idx(seg_idx),
		.den(den),
		.step(step),
		.busy(busy),
		.strobe(strobe),
		.last(last)
	);

	brs_datapath #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk(clk),
		.req(req),
		.cmd(cmd),
		.seg_idx(seg_idx),
		.den(den),
		.step(step),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.seg_width(seg_width),
		.heading(heading)
	);

	always_comb begin
		result.seg_index = 6'(seg_idx);
		result.pos_x     = pos_x;
		result.pos_y     = pos_y;
		result.seg_width = seg_width;
		result.heading   = heading;
		result.last      = last;
	end

endmodule

FILE: rtl/brs_datapath.sv
// datapath: t divider, shared lerp multiplier on a four-entry shift chain, cordic unit
module brs_datapath #(
	parameter int MAX_SEGMENTS = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  brs_pkg::req_t                       req,
	input  brs_pkg::cmd_t                       cmd,
	input  logic [$clog2(MAX_SEGMENTS)-1:0]     seg_idx,
	input  logic [$clog2(MAX_SEGMENTS)-1:0]     den,
	input  logic [$clog2(CORDIC_STEPS)-1:0]     step,
	output logic signed [15:0]                  pos_x,
	output logic signed [15:0]                  pos_y,
	output logic [15:0]                         seg_width,
	output logic signed [15:0]                  heading
);
	import brs_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);

	req_t                      req_q;
	logic [IW-1:0]             rem_q;
	logic [15:0]               quo_q;
	logic                      eq_q;
	logic [T_W-1:0]            t_q, tl_q, tr_q;
	logic signed [VAL_W-1:0]   w_q [4];
	logic signed [35:0]        prod_s1;
	logic signed [VAL_W-1:0]   a_s1;
	logic signed [15:0]        lx_q, ly_q, cx_q, cy_q, rx_q, ry_q;
	logic [15:0]               wid_q;
	logic signed [CRD_W-1:0]   x_q, y_q;
	logic [15:0]               z_q;
	logic                      zero_q;

	logic [IW:0]               r2;
	logic                      ge;
	logic [T_W-1:0]            t_full, t_sel, tl_c, tr_c;
	logic [T_W:0]              tr_w;
	logic signed [17:0]        diff;
	logic signed [35:0]        prod_c, rnd;
	logic signed [VAL_W-1:0]   lerp_res;
	logic signed [16:0]        dx, dy;
	logic signed [CRD_W-1:0]   xs, ys;
	logic [15:0]               ang;

	always_comb begin
		r2 = {rem_q, 1'b0};
		ge = (r2 >= {1'b0, den});
		t_full = eq_q ? T_ONE : {1'b0, quo_q};
		tl_c = (t_full > T_OFFSET) ? (t_full - T_OFFSET) : '0;
		tr_w = {1'b0, t_full} + {1'b0, T_OFFSET};
		tr_c = (tr_w < {1'b0, T_ONE}) ? tr_w[T_W-1:0] : T_ONE;
		case (cmd.pass)
			PASS_LX, PASS_LY: t_sel = tl_q;
			PASS_RX, PASS_RY: t_sel = tr_q;
			default:          t_sel = t_q;
		endcase
		diff = {w_q[1][VAL_W-1], w_q[1]} - {w_q[0][VAL_W-1], w_q[0]};
		prod_c = diff * $signed({1'b0, t_sel});
		rnd = prod_s1 + 36'sd32768;
		lerp_res = a_s1 + VAL_W'(rnd >>> 16);
		dx = {lx_q[15], lx_q} - {rx_q[15], rx_q};
		dy = {ly_q[15], ly_q} - {ry_q[15], ry_q};
		xs = x_q >>> step;
		ys = y_q >>> step;
		ang = atan_tab(5'(step));
	end

	always_ff @(posedge clk) begin
		if (cmd.start_load) begin
			req_q <= req;
		end
		if (cmd.div_init) begin
			rem_q <= seg_idx;
			quo_q <= '0;
			eq_q  <= (seg_idx == den);
		end
		if (cmd.div_step) begin
			rem_q <= ge ? IW'(r2 - {1'b0, den}) : r2[IW-1:0];
			quo_q <= {quo_q[14:0], ge};
		end
		if (cmd.t_fix) begin
			t_q  <= t_full;
			tl_q <= tl_c;
			tr_q <= tr_c;
		end
		if (cmd.load) begin
			if (cmd.pass == PASS_WID) begin
				w_q[0] <= {1'b0, req_q.width_head};
				w_q[1] <= {1'b0, req_q.width_tail};
				w_q[2] <= '0;
				w_q[3] <= '0;
			end else if (!cmd.pass[0]) begin
				w_q[0] <= {req_q.p0_x[15], req_q.p0_x};
				w_q[1] <= {req_q.p1_x[15], req_q.p1_x};
				w_q[2] <= {req_q.p2_x[15], req_q.p2_x};
				w_q[3] <= {req_q.p3_x[15], req_q.p3_x};
			end else begin
				w_q[0] <= {req_q.p0_y[15], req_q.p0_y};
				w_q[1] <= {req_q.p1_y[15], req_q.p1_y};
				w_q[2] <= {req_q.p2_y[15], req_q.p2_y};
				w_q[3] <= {req_q.p3_y[15], req_q.p3_y};
			end
		end
		if (cmd.mul) begin
			prod_s1 <= prod_c;
			a_s1    <= w_q[0];
		end
		if (cmd.push || cmd.drop) begin
			w_q[0] <= w_q[1];
			w_q[1] <= w_q[2];
			w_q[2] <= w_q[3];
			w_q[3] <= cmd.push ? lerp_res : '0;
		end
		if (cmd.save) begin
			case (cmd.pass)
				PASS_LX: lx_q  <= w_q[3][15:0];
				PASS_LY: ly_q  <= w_q[3][15:0];
				PASS_CX: cx_q  <= w_q[3][15:0];
				PASS_CY: cy_q  <= w_q[3][15:0];
				PASS_RX: rx_q  <= w_q[3][15:0];
				PASS_RY: ry_q  <= w_q[3][15:0];
				default: wid_q <= w_q[3][15:0];
			endcase
		end
		if (cmd.cinit) begin
			zero_q <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				if (dy >= 0) begin
					x_q <= CRD_W'(dy);
					y_q <= -CRD_W'(dx);
					z_q <= 16'd16384;
				end else begin
					x_q <= -CRD_W'(dy);
					y_q <= CRD_W'(dx);
					z_q <= 16'hC000;
				end
			end else begin
				x_q <= CRD_W'(dx);
				y_q <= CRD_W'(dy);
				z_q <= '0;
			end
		end
		if (cmd.cstep) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
	end

	assign pos_x     = cx_q;
	assign pos_y     = cy_q;
	assign seg_width = wid_q;
	assign heading   = zero_q ? 16'sd0 : $signed(z_q);

endmodule

FILE: rtl/brs_ctrl.sv
// controller: sequences division, de casteljau passes, cordic steps and result beats
module brs_ctrl #(
	parameter int MAX_SEGMENTS = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [6:0]                          seg_total,
	output brs_pkg::cmd_t                       cmd,
	output logic [$clog2(MAX_SEGMENTS)-1:0]     seg_idx,
	output logic [$clog2(MAX_SEGMENTS)-1:0]     den,
	output logic [$clog2(CORDIC_STEPS)-1:0]     step,
	output logic                                busy,
	output logic                                strobe,
	output logic                                last
);
	import brs_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SW = $clog2(CORDIC_STEPS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DINIT = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_TFIX  = 4'd3;
	localparam logic [3:0] S_LOAD  = 4'd4;
	localparam logic [3:0] S_OP    = 4'd5;
	localparam logic [3:0] S_PUSH  = 4'd6;
	localparam logic [3:0] S_SAVE  = 4'd7;
	localparam logic [3:0] S_CINIT = 4'd8;
	localparam logic [3:0] S_CSTEP = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;

	logic [3:0]    state_q, state_d;
	logic [IW-1:0] i_q, i_d, nm1_q, nm1_d;
	logic [2:0]    pass_q, pass_d;
	logic [3:0]    pc_q, pc_d, dcnt_q, dcnt_d;
	logic [SW-1:0] step_q, step_d;
	logic [CW-1:0] n_c;
	logic [3:0]    pc_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			nm1_q   <= '0;
			pass_q  <= '0;
			pc_q    <= '0;
			dcnt_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			nm1_q   <= nm1_d;
			pass_q  <= pass_d;
			pc_q    <= pc_d;
			dcnt_q  <= dcnt_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		nm1_d   = nm1_q;
		pass_d  = pass_q;
		pc_d    = pc_q;
		dcnt_d  = dcnt_q;
		step_d  = step_q;
		cmd     = '0;
		cmd.pass = pass_q;
		pc_last = (pass_q == PASS_WID) ? 4'd0 : PROG_LAST;
		if (int'(seg_total) > MAX_SEGMENTS) begin
			n_c = CW'(MAX_SEGMENTS);
		end else begin
			n_c = CW'(seg_total);
		end
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.start_load = 1'b1;
					nm1_d = IW'(n_c - CW'(1));
					i_d   = '0;
					if (n_c != '0) begin
						state_d = S_DINIT;
					end
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				dcnt_d  = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				dcnt_d = dcnt_q + 4'd1;
				if (dcnt_q == 4'd15) begin
					state_d = S_TFIX;
				end
			end
			S_TFIX: begin
				cmd.t_fix = 1'b1;
				pass_d  = PASS_LX;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				pc_d    = '0;
				state_d = S_OP;
			end
			S_OP: begin
				if (CAST_PROG[pc_q] == OP_LERP) begin
					cmd.mul = 1'b1;
					state_d = S_PUSH;
				end else begin
					cmd.drop = 1'b1;
					pc_d = pc_q + 4'd1;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				if (pc_q == pc_last) begin
					state_d = S_SAVE;
				end else begin
					pc_d    = pc_q + 4'd1;
					state_d = S_OP;
				end
			end
			S_SAVE: begin
				cmd.save = 1'b1;
				if (pass_q == PASS_WID) begin
					state_d = S_CINIT;
				end else begin
					pass_d  = pass_q + 3'd1;
					state_d = S_LOAD;
				end
			end
			S_CINIT: begin
				cmd.cinit = 1'b1;
				step_d  = '0;
				state_d = S_CSTEP;
			end
			S_CSTEP: begin
				cmd.cstep = 1'b1;
				if (step_q == SW'(CORDIC_STEPS - 1)) begin
					state_d = S_EMIT;
				end else begin
					step_d = step_q + SW'(1);
				end
			end
			S_EMIT: begin
				if (i_q == nm1_q) begin
					state_d = S_IDLE;
				end else begin
					i_d     = i_q + IW'(1);
					state_d = S_DINIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign seg_idx = i_q;
	assign den     = (nm1_q == '0) ? IW'(1) : nm1_q;
	assign step    = step_q;
	assign busy    = (state_q != S_IDLE);
	assign strobe  = (state_q == S_EMIT);
	assign last    = (i_q == nm1_q);

endmodule

FILE: rtl/brs_checker.sv
// port-level checker for the bezier ribbon sampler and its bind
module brs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input brs_pkg::req_t req,
	input logic          strobe,
	input brs_pkg::res_t result
);
	import brs_pkg::*;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result beat while not busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !busy)
		else $error("still busy after last beat");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.seg_total != 7'd0) |=> busy)
		else $error("request beat not taken up");

	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result beats back to back");

	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !strobe)
		else $error("result beat in the cycle a request starts");

endmodule

bind bezier_ribbon_sampler_top brs_checker u_brs_checker (.*);
